// ===== design/ipe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipe_pkg
// Types, constants and the edge successor table of the polygon extractor.
// ----------------------------------------------------------------------------
package ipe_pkg;

  localparam int unsigned NUM_EDGES = 12;

  typedef logic [3:0] edge_t;

  typedef struct packed {
    logic [11:0] cut_mask;
    logic [11:0] side_mask;
  } in_req_t;

  typedef struct packed {
    logic [3:0] first_edge;
    logic [3:0] second_edge;
    logic [3:0] third_edge;
    logic [1:0] polygon_number;
    logic       has_triangle;
    logic       last_of_cube;
  } out_res_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic begin_walk;
    logic visit;
    logic finish;
  } ipe_cmd_t;

  typedef struct packed {
    logic start_done;
    logic start_hit;
    logic walk_more;
  } ipe_status_t;

  localparam edge_t NEXT_EDGE_TAB [0:11][0:1][0:2] = '{
    '{'{4'd9,  4'd1,  4'd8},  '{4'd4,  4'd3,  4'd7}},
    '{'{4'd6,  4'd2,  4'd5},  '{4'd8,  4'd0,  4'd9}},
    '{'{4'd10, 4'd3,  4'd11}, '{4'd5,  4'd1,  4'd6}},
    '{'{4'd7,  4'd0,  4'd4},  '{4'd11, 4'd2,  4'd10}},
    '{'{4'd3,  4'd7,  4'd0},  '{4'd8,  4'd5,  4'd11}},
    '{'{4'd11, 4'd4,  4'd8},  '{4'd1,  4'd6,  4'd2}},
    '{'{4'd2,  4'd5,  4'd1},  '{4'd9,  4'd7,  4'd10}},
    '{'{4'd10, 4'd6,  4'd9},  '{4'd0,  4'd4,  4'd3}},
    '{'{4'd5,  4'd11, 4'd4},  '{4'd0,  4'd9,  4'd1}},
    '{'{4'd1,  4'd8,  4'd0},  '{4'd7,  4'd10, 4'd6}},
    '{'{4'd6,  4'd9,  4'd7},  '{4'd3,  4'd11, 4'd2}},
    '{'{4'd2,  4'd10, 4'd3},  '{4'd4,  4'd8,  4'd5}}
  };

endpackage
`default_nettype wire

// ===== design/isocube_polygon_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isocube_polygon_extractor
// Walks the cut edges of one marching-cubes cell and emits its polygons as
// triangle fans of edge-index triples.
//
//   Channel   Ports                     Handshake
//   request   start, busy, in_req       taken when start is high, busy low
//   result    out_valid, out_res        one-cycle strobe, cannot be stalled
//
// A cube is handled as a scan over the start edges, with a walk of one
// visited edge per step from each unvisited cut start edge, a check for
// the end of the scan, a final result and a return to idle to take the
// next request. Results are held in a pending register, then registered
// out, the last one flagged. Reset is synchronous and leaves the block idle.
// ----------------------------------------------------------------------------
module isocube_polygon_extractor (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ipe_pkg::in_req_t  in_req,
  output logic                   out_valid,
  output ipe_pkg::out_res_t      out_res
);

  ipe_pkg::ipe_cmd_t    cmd;
  ipe_pkg::ipe_status_t status;

  ipe_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  ipe_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

// ===== design/ipe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipe_ctrl
// Controller that sequences the start-edge scan, the edge walks and the
// final result of each cube.
// ----------------------------------------------------------------------------
module ipe_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ipe_pkg::ipe_status_t status,
  output ipe_pkg::ipe_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.start_done) begin
          state_nxt = ST_FINISH;
        end else if (status.start_hit) begin
          cmd.begin_walk = 1'b1;
          state_nxt      = ST_WALK;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_WALK: begin
        cmd.visit = 1'b1;
        if (!status.walk_more) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

// ===== design/ipe_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipe_datapath
// Edge masks, visited set, walk registers, fan triangle builder, a pending
// register that holds back one triangle to mark the last of a cube, and the output register.
// ----------------------------------------------------------------------------
module ipe_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ipe_pkg::in_req_t     in_req,
  input  wire ipe_pkg::ipe_cmd_t    cmd,
  output ipe_pkg::ipe_status_t      status,
  output logic                      out_valid,
  output ipe_pkg::out_res_t         out_res
);

  logic [11:0]       cut_r, cut_nxt;
  logic [11:0]       side_r, side_nxt;
  logic [11:0]       visited_r, visited_nxt;
  logic [3:0]        start_r, start_nxt;
  ipe_pkg::edge_t    cur_r, cur_nxt;
  logic [1:0]        nv_r, nv_nxt;
  ipe_pkg::edge_t    anchor_r, anchor_nxt;
  ipe_pkg::edge_t    prev_r, prev_nxt;
  logic [1:0]        poly_r, poly_nxt;
  ipe_pkg::out_res_t pend_r, pend_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  ipe_pkg::out_res_t out_res_r, out_res_nxt;

  logic [11:0]       visit_set;
  logic              dir;
  ipe_pkg::edge_t    cand0, cand1, cand2;
  ipe_pkg::edge_t    cand;
  logic              found;
  logic              new_tri;
  ipe_pkg::out_res_t tri_res;

  always_comb begin
    visit_set = visited_r | (12'b1 << cur_r);
    dir       = side_r[cur_r];
    cand0     = ipe_pkg::NEXT_EDGE_TAB[cur_r][dir][0];
    cand1     = ipe_pkg::NEXT_EDGE_TAB[cur_r][dir][1];
    cand2     = ipe_pkg::NEXT_EDGE_TAB[cur_r][dir][2];
    found     = 1'b1;
    if (cut_r[cand0]) begin
      cand = cand0;
    end else if (cut_r[cand1]) begin
      cand = cand1;
    end else if (cut_r[cand2]) begin
      cand = cand2;
    end else begin
      cand  = cand0;
      found = 1'b0;
    end
  end

  assign status.start_done = (start_r == 4'(ipe_pkg::NUM_EDGES));
  assign status.start_hit  = (((cut_r & ~visited_r) >> start_r) & 12'd1) != 12'd0;
  assign status.walk_more  = found && !visit_set[cand];

  assign new_tri = cmd.visit && (nv_r == 2'd2);

  always_comb begin
    tri_res                = '0;
    tri_res.first_edge     = anchor_r;
    tri_res.second_edge    = prev_r;
    tri_res.third_edge     = cur_r;
    tri_res.polygon_number = poly_r;
    tri_res.has_triangle   = 1'b1;
  end

  always_comb begin
    cut_nxt        = cut_r;
    side_nxt       = side_r;
    visited_nxt    = visited_r;
    start_nxt      = start_r;
    cur_nxt        = cur_r;
    nv_nxt         = nv_r;
    anchor_nxt     = anchor_r;
    prev_nxt       = prev_r;
    poly_nxt       = poly_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = 1'b0;
    out_res_nxt    = out_res_r;

    if (cmd.load) begin
      cut_nxt        = in_req.cut_mask;
      side_nxt       = in_req.side_mask;
      visited_nxt    = '0;
      start_nxt      = '0;
      poly_nxt       = '0;
      pend_valid_nxt = 1'b0;
    end

    if (cmd.advance) begin
      start_nxt = start_r + 4'd1;
    end

    if (cmd.begin_walk) begin
      cur_nxt = start_r;
      nv_nxt  = '0;
    end

    if (cmd.visit) begin
      visited_nxt = visit_set;
      prev_nxt    = cur_r;
      cur_nxt     = cand;
      if (nv_r == 2'd0) begin
        anchor_nxt = cur_r;
      end
      if (nv_r != 2'd2) begin
        nv_nxt = nv_r + 2'd1;
      end
      if (!status.walk_more && (nv_r == 2'd2)) begin
        poly_nxt = poly_r + 2'd1;
      end
    end

    if (new_tri) begin
      pend_nxt       = tri_res;
      pend_valid_nxt = 1'b1;
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = pend_r;
      end
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (pend_valid_r) begin
        out_res_nxt = pend_r;
      end else begin
        out_res_nxt = '0;
      end
      out_res_nxt.last_of_cube = 1'b1;
      pend_valid_nxt           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cut_r     <= cut_nxt;
    side_r    <= side_nxt;
    visited_r <= visited_nxt;
    start_r   <= start_nxt;
    cur_r     <= cur_nxt;
    nv_r      <= nv_nxt;
    anchor_r  <= anchor_nxt;
    prev_r    <= prev_nxt;
    poly_r    <= poly_nxt;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

// ===== dv/ipe_fan_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipe_fan_checker
// Watches the request and result channels of the polygon extractor. For every
// accepted cube it walks the cut edges itself, builds the expected triangle
// fans and compares each result strobe, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module ipe_fan_checker
  import ipe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_req_t     in_req,
  input  logic        out_valid,
  input  out_res_t    out_res,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);

  localparam edge_t EDGE_NEXT [0:11][0:1][0:2] = '{
    '{'{4'd9,  4'd1,  4'd8},  '{4'd4,  4'd3,  4'd7}},
    '{'{4'd6,  4'd2,  4'd5},  '{4'd8,  4'd0,  4'd9}},
    '{'{4'd10, 4'd3,  4'd11}, '{4'd5,  4'd1,  4'd6}},
    '{'{4'd7,  4'd0,  4'd4},  '{4'd11, 4'd2,  4'd10}},
    '{'{4'd3,  4'd7,  4'd0},  '{4'd8,  4'd5,  4'd11}},
    '{'{4'd11, 4'd4,  4'd8},  '{4'd1,  4'd6,  4'd2}},
    '{'{4'd2,  4'd5,  4'd1},  '{4'd9,  4'd7,  4'd10}},
    '{'{4'd10, 4'd6,  4'd9},  '{4'd0,  4'd4,  4'd3}},
    '{'{4'd5,  4'd11, 4'd4},  '{4'd0,  4'd9,  4'd1}},
    '{'{4'd1,  4'd8,  4'd0},  '{4'd7,  4'd10, 4'd6}},
    '{'{4'd6,  4'd9,  4'd7},  '{4'd3,  4'd11, 4'd2}},
    '{'{4'd2,  4'd10, 4'd3},  '{4'd4,  4'd8,  4'd5}}
  };

  out_res_t expected_tris[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  task automatic predict_fans(input in_req_t req);
    logic [11:0] visited;
    edge_t       path [0:11];
    out_res_t    tris [0:9];
    int          n;
    int          poly;
    int          count;
    edge_t       e;
    edge_t       cand;
    logic        found;
    logic        dir;
    visited = '0;
    poly    = 0;
    count   = 0;
    for (int s = 0; s < 12; s++) begin
      n     = 0;
      e     = edge_t'(s);
      found = req.cut_mask[e];
      while (found && !visited[e] && n < 12) begin
        dir     = req.side_mask[e];
        path[n] = e;
        n++;
        visited[e] = 1'b1;
        found      = 1'b0;
        for (int m = 0; m < 3 && !found; m++) begin
          cand = EDGE_NEXT[e][dir][m];
          if (req.cut_mask[cand]) begin
            e     = cand;
            found = 1'b1;
          end
        end
      end
      if (n > 2) begin
        for (int m = 1; m + 1 < n && count < 10; m++) begin
          tris[count] = '{first_edge: path[0], second_edge: path[m],
                          third_edge: path[m+1], polygon_number: poly[1:0],
                          has_triangle: 1'b1, last_of_cube: 1'b0};
          count++;
        end
        poly++;
      end
    end
    if (count == 0) begin
      tris[0] = '0;
      count   = 1;
    end
    tris[count-1].last_of_cube = 1'b1;
    for (int k = 0; k < count; k++) expected_tris.push_back(tris[k]);
  endtask

  always @(posedge clk) begin
    out_res_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_tris.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] result with nothing expected: %h", $realtime, out_res);
        end else begin
          want = expected_tris.pop_front();
          if (out_res.first_edge !== want.first_edge ||
              out_res.second_edge !== want.second_edge ||
              out_res.third_edge !== want.third_edge ||
              out_res.polygon_number !== want.polygon_number ||
              out_res.has_triangle !== want.has_triangle ||
              out_res.last_of_cube !== want.last_of_cube) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"[%0t] mismatch: expected %0d %0d %0d poly %0d tri %0d last %0d,",
                        " got %0d %0d %0d poly %0d tri %0d last %0d"}, $realtime,
                       want.first_edge, want.second_edge, want.third_edge,
                       want.polygon_number, want.has_triangle, want.last_of_cube,
                       out_res.first_edge, out_res.second_edge, out_res.third_edge,
                       out_res.polygon_number, out_res.has_triangle,
                       out_res.last_of_cube);
          end
        end
      end
      if (start && !busy) predict_fans(in_req);
    end
    pending_count = expected_tris.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives cube requests into the polygon extractor: a directed set of edge
// masks first, then random masks of varied density under three sender idling
// profiles. The fan checker predicts and compares; this module gives the
// verdict once every expected result has arrived.
// ----------------------------------------------------------------------------
module tb_top;
  import ipe_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_CUBES = 390;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_req_t     in_req;
  logic        out_valid;
  out_res_t    out_res;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned cycle_count;

  isocube_polygon_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  ipe_fan_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_res        (out_res),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [11:0] pick_mask();
    logic [11:0] m;
    case ($urandom_range(3))
      0: m = 12'($urandom);
      1: m = 12'($urandom & $urandom);
      2: m = 12'($urandom | $urandom);
      default: begin
        m = '0;
        repeat ($urandom_range(6, 3)) m[$urandom_range(11)] = 1'b1;
      end
    endcase
    return m;
  endfunction

  // Called at a falling edge; returns at the first falling edge after acceptance at which busy is low again.
  task automatic send_cube(input in_req_t req, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start  <= 1'b0;
      in_req <= in_req_t'($urandom);
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  initial begin
    in_req_t directed [$];
    in_req_t req;
    int      idle_pct;
    rst_n  = 1'b0;
    start  = 1'b0;
    in_req = '0;
    directed = '{
      '{cut_mask: 12'h000, side_mask: 12'h000},
      '{cut_mask: 12'h000, side_mask: 12'hFFF},
      '{cut_mask: 12'hFFF, side_mask: 12'h000},
      '{cut_mask: 12'hFFF, side_mask: 12'hFFF},
      '{cut_mask: 12'hFFF, side_mask: 12'h555},
      '{cut_mask: 12'hFFF, side_mask: 12'hAAA},
      '{cut_mask: 12'h301, side_mask: 12'h000},
      '{cut_mask: 12'h301, side_mask: 12'hFFF},
      '{cut_mask: 12'h001, side_mask: 12'h000},
      '{cut_mask: 12'h800, side_mask: 12'hFFF},
      '{cut_mask: 12'h201, side_mask: 12'h000},
      '{cut_mask: 12'h555, side_mask: 12'hAAA},
      '{cut_mask: 12'hAAA, side_mask: 12'h555},
      '{cut_mask: 12'hF0F, side_mask: 12'h0F0},
      '{cut_mask: 12'h0F0, side_mask: 12'hF0F},
      '{cut_mask: 12'h33C, side_mask: 12'hC3C},
      '{cut_mask: 12'h7FE, side_mask: 12'h001},
      '{cut_mask: 12'hE07, side_mask: 12'h1F8},
      '{cut_mask: 12'h3F3, side_mask: 12'hC0C},
      '{cut_mask: 12'hFFE, side_mask: 12'h000}
    };
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_cube(directed[i], 28);
    for (int i = 0; i < RANDOM_CUBES; i++) begin
      idle_pct = (i < RANDOM_CUBES / 3) ? 28 : (i < 2 * RANDOM_CUBES / 3) ? 78 : 0;
      req.cut_mask  = pick_mask();
      req.side_mask = 12'($urandom);
      send_cube(req, idle_pct);
    end
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ipe_pkg.sv
design/ipe_ctrl.sv
design/ipe_datapath.sv
design/isocube_polygon_extractor.sv
dv/ipe_fan_checker.sv
dv/tb_top.sv
